// ----- rtl/tdfe_pkg.sv -----
package tdfe_pkg;

  // Character codes that the parser looks for.
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // Result status codes.
  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_LAST     = 3'd1;
  localparam logic [2:0] ST_MISMATCH = 3'd2;
  localparam logic [2:0] ST_EARLY    = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;

  // Item modes.
  localparam logic MODE_NAME = 1'b0;
  localparam logic MODE_DOC  = 1'b1;

endpackage

// ----- rtl/tagged_document_field_extractor.sv -----
// A result appears in the output register in the cycle after the document byte that
// causes it is accepted. Throughput: one item per cycle while in_stall is low, name
// loads and document bytes alike; the name memory is read ahead from the next parser
// state, so its single read port never stalls.
// Reset (rst, synchronous) rearms the parser and sets field_count to one; the name memory
// and the name lengths keep whatever they held and must be loaded before use.
module tagged_document_field_extractor #(
  parameter int MAX_FIELDS = 16,
  parameter int NAME_BYTES = 32,
  parameter int DOC_BYTES  = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [4:0]  name_slot,
  input  logic [4:0]  name_pos,
  input  logic [7:0]  data_byte,
  input  logic        is_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  field_number,
  output logic [15:0] content_offset,
  output logic [15:0] content_length,
  output logic [2:0]  status
);

  localparam int SLOTS = MAX_FIELDS + 1;
  localparam int DEPTH = SLOTS * NAME_BYTES;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = $clog2(SLOTS);
  localparam int NPW   = $clog2(NAME_BYTES);
  localparam int LW    = $clog2(NAME_BYTES + 1);
  localparam int IW    = $clog2(NAME_BYTES + 2);
  localparam int PW    = $clog2(DOC_BYTES + 1);
  localparam int WB    = NAME_BYTES + 3;

  typedef enum logic [2:0] {
    PH_OPEN, PH_TO_GT, PH_SPACE, PH_BODY, PH_IDLE
  } phase_t;

  // Name bytes of all slots live in one synchronous memory. The parser only ever needs one
  // name byte per document byte while it checks an open tag, and that byte is fetched in
  // the cycle before it is needed.
  logic [7:0]    name_mem [DEPTH];
  logic [7:0]    rd_data;
  logic [LW-1:0] name_len [SLOTS];

  // The name of the field being parsed is captured from the open tag as it streams past.
  // The close tag is found by comparing a window of the newest body bytes against
  // "</name>" in parallel, so a name that changes inside a field is compared as it stands.
  logic [7:0]         cur_name [NAME_BYTES];
  logic [WB-1:0][7:0] close_win, close_win_next, win_shift;
  logic               close_hit;

  phase_t        phase, phase_next;
  logic [FW-1:0] cur_field, cur_field_next;
  logic [PW-1:0] byte_pos, byte_pos_next;
  logic [IW-1:0] tag_idx, tag_idx_next;
  logic [PW-1:0] content_start, content_start_next;
  logic [4:0]    field_count;

  logic          accept, name_wr, doc_step;
  logic          slot_ok, pos_ok;
  logic [FW+4:0] slot_ext;
  logic [NPW+4:0] pos_ext;
  logic [FW-1:0] wr_slot;
  logic [NPW-1:0] wr_pos;
  logic [AW-1:0] wr_addr, rd_addr_next;
  logic [IW-1:0] rd_idx_m1;
  logic [LW-1:0] cur_len;
  logic          is_space;
  logic [7:0]    want;
  logic          capture;
  logic [IW-1:0] capture_idx;
  logic [31:0]   wanted, seen32, clen32, off32, field32;

  logic          res;
  logic [2:0]    res_status;
  logic [15:0]   res_offset, res_length;
  logic [4:0]    res_field;

  // The output register parts the two sides: only a result that cannot leave holds input.
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign name_wr  = accept && (mode == tdfe_pkg::MODE_NAME) && slot_ok && pos_ok;
  assign doc_step = accept && (mode == tdfe_pkg::MODE_DOC);

  assign slot_ok  = int'(name_slot) < SLOTS;
  assign pos_ok   = int'(name_pos) < NAME_BYTES;
  assign slot_ext = {{FW{1'b0}}, name_slot};
  assign pos_ext  = {{NPW{1'b0}}, name_pos};
  assign wr_slot  = slot_ext[FW-1:0];
  assign wr_pos   = pos_ext[NPW-1:0];
  assign wr_addr  = AW'(int'(wr_slot) * NAME_BYTES + int'(wr_pos));

  assign cur_len  = name_len[cur_field];
  assign is_space = (data_byte == tdfe_pkg::CH_SP) || (data_byte == tdfe_pkg::CH_TAB) ||
                    (data_byte == tdfe_pkg::CH_NL);

  // The window with this byte shifted in, and whether it now ends with "</name>".
  always_comb begin
    win_shift = {close_win[WB-2:0], data_byte};
    close_hit = (win_shift[0] == tdfe_pkg::CH_GT) &&
                (win_shift[int'(cur_len) + 1] == tdfe_pkg::CH_SLASH) &&
                (win_shift[int'(cur_len) + 2] == tdfe_pkg::CH_LT);
    for (int j = 0; j < NAME_BYTES; j++) begin
      if (j < int'(cur_len) && win_shift[int'(cur_len) - j] != cur_name[j]) begin
        close_hit = 1'b0;
      end
    end
  end

  // One document byte through the parser.
  always_comb begin
    phase_next         = phase;
    cur_field_next     = cur_field;
    byte_pos_next      = byte_pos;
    tag_idx_next       = tag_idx;
    content_start_next = content_start;
    close_win_next     = close_win;
    res                = 1'b0;
    res_status         = tdfe_pkg::ST_FOUND;
    off32              = '0;
    clen32             = '0;
    want               = tdfe_pkg::CH_LT;
    capture            = 1'b0;
    capture_idx        = '0;
    wanted             = (field_count == 5'd0) ? 32'd1 :
                         (int'(field_count) > MAX_FIELDS) ? 32'(MAX_FIELDS) :
                         32'(field_count);
    seen32             = 32'(byte_pos) + 32'd1 - 32'(content_start);

    if (doc_step) begin
      if (phase != PH_IDLE && int'(byte_pos) >= DOC_BYTES) begin
        res        = 1'b1;
        res_status = tdfe_pkg::ST_TOO_LONG;
        phase_next = PH_IDLE;
      end

      if (phase_next == PH_SPACE && !is_space) begin
        phase_next   = PH_OPEN;
        tag_idx_next = '0;
      end

      unique case (phase_next) inside
        PH_OPEN: begin
          want = (tag_idx_next == '0) ? tdfe_pkg::CH_LT : rd_data;
          if (data_byte != want) begin
            res        = 1'b1;
            res_status = tdfe_pkg::ST_MISMATCH;
            phase_next = PH_IDLE;
          end else begin
            if (tag_idx_next != '0) begin
              capture     = 1'b1;
              capture_idx = tag_idx_next - 1'b1;
            end
            tag_idx_next = tag_idx_next + 1'b1;
            if (int'(tag_idx_next) >= int'(cur_len) + 1) phase_next = PH_TO_GT;
          end
        end
        PH_TO_GT: begin
          if (data_byte == tdfe_pkg::CH_GT) begin
            if (cur_field == '0) begin
              cur_field_next = FW'(1);
              phase_next     = PH_SPACE;
            end else begin
              content_start_next = byte_pos + 1'b1;
              close_win_next     = '0;
              phase_next         = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          close_win_next = win_shift;
          if (seen32 >= 32'(cur_len) + 32'd3 && close_hit) begin
            res    = 1'b1;
            off32  = 32'(content_start);
            clen32 = seen32 - 32'(cur_len) - 32'd3;
            if (32'(cur_field) >= wanted) begin
              res_status = tdfe_pkg::ST_LAST;
              phase_next = PH_IDLE;
            end else begin
              res_status     = tdfe_pkg::ST_FOUND;
              cur_field_next = cur_field + 1'b1;
              phase_next     = PH_SPACE;
            end
          end
        end
        PH_SPACE, PH_IDLE: begin
        end
        default: begin
        end
      endcase

      if (int'(byte_pos) < DOC_BYTES) byte_pos_next = byte_pos + 1'b1;

      // The last byte reports an unfinished document against the field reached, which
      // overrides a field found by that same byte, and rearms for the next document.
      if (is_last) begin
        if (phase_next != PH_IDLE) begin
          res        = 1'b1;
          res_status = tdfe_pkg::ST_EARLY;
          off32      = '0;
          clen32     = '0;
        end
        field32            = 32'(cur_field_next);
        phase_next         = PH_OPEN;
        cur_field_next     = '0;
        byte_pos_next      = '0;
        tag_idx_next       = '0;
        content_start_next = '0;
        close_win_next     = '0;
      end else begin
        field32 = 32'(cur_field_next);
      end
    end else begin
      field32 = 32'(cur_field);
    end

    // A mismatch or an overlong document names the field current when it was found; so does a found field.
    if (res && (res_status == tdfe_pkg::ST_MISMATCH || res_status == tdfe_pkg::ST_TOO_LONG)) begin
      field32 = 32'(cur_field);
    end
    if (res && (res_status == tdfe_pkg::ST_FOUND || res_status == tdfe_pkg::ST_LAST)) begin
      field32 = 32'(cur_field);
    end

    res_field  = field32[4:0];
    res_offset = off32[15:0];
    res_length = clen32[15:0];
  end

  // Prefetch address: the name byte that the next open-tag byte will be checked against.
  assign rd_idx_m1    = (tag_idx_next == '0) ? '0 : tag_idx_next - 1'b1;
  assign rd_addr_next = AW'(int'(cur_field_next) * NAME_BYTES + int'(rd_idx_m1[NPW-1:0]));

  always_ff @(posedge clk) begin
    if (name_wr) begin
      name_mem[wr_addr] <= data_byte;
    end
    // A write to the entry being fetched is forwarded.
    if (name_wr && wr_addr == rd_addr_next) begin
      rd_data <= data_byte;
    end else begin
      rd_data <= name_mem[rd_addr_next];
    end
  end

  always_ff @(posedge clk) begin
    if (name_wr && is_last) begin
      name_len[wr_slot] <= LW'(int'(wr_pos) + 1);
    end
    if (capture) begin
      cur_name[capture_idx[NPW-1:0]] <= data_byte;
    end
    // A name loaded into the slot of the current field takes effect at once.
    if (name_wr && wr_slot == cur_field) begin
      cur_name[wr_pos] <= data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_OPEN;
      cur_field     <= '0;
      byte_pos      <= '0;
      tag_idx       <= '0;
      content_start <= '0;
      close_win     <= '0;
      field_count   <= 5'd1;
      out_valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      cur_field     <= cur_field_next;
      byte_pos      <= byte_pos_next;
      tag_idx       <= tag_idx_next;
      content_start <= content_start_next;
      close_win     <= close_win_next;
      if (cfg_wr_en) field_count <= cfg_wr_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (res) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res) begin
      field_number   <= res_field;
      content_offset <= res_offset;
      content_length <= res_length;
      status         <= res_status;
    end
  end

  a_body_has_field: assert property (@(posedge clk) disable iff (rst)
    phase == PH_BODY |-> cur_field != '0)
    else $error("body phase with the document tag as current field");

  a_field_in_range: assert property (@(posedge clk) disable iff (rst)
    int'(cur_field) <= MAX_FIELDS)
    else $error("current field beyond the last slot");

  a_pos_saturates: assert property (@(posedge clk) disable iff (rst)
    int'(byte_pos) <= DOC_BYTES)
    else $error("byte position beyond the document limit");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input held while the output register is empty");

endmodule

// ----- sim/tagged_document_field_extractor_tb.sv -----
`timescale 1ns / 100ps

module tagged_document_field_extractor_tb;

  localparam int SLOT_COUNT  = 17;
  localparam int NAME_LEN    = 32;
  localparam int WINDOW      = NAME_LEN + 3;
  localparam int DOC_LIMIT   = 65536;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEM_TARGET = 1650;

  // Parser phases of the local copy of the block.
  typedef enum int {P_OPEN, P_TO_GT, P_SPACE, P_BODY, P_IDLE} phase_t;

  typedef struct packed {
    logic [4:0]  fnum;
    logic [15:0] offset;
    logic [15:0] length;
    logic [2:0]  code;
  } field_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        mode = tdfe_pkg::MODE_NAME;
  logic [4:0]  name_slot = '0;
  logic [4:0]  name_pos = '0;
  logic [7:0]  data_byte = '0;
  logic        is_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  field_number;
  logic [15:0] content_offset;
  logic [15:0] content_length;
  logic [2:0]  status;

  tagged_document_field_extractor dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .name_slot(name_slot), .name_pos(name_pos),
    .data_byte(data_byte), .is_last(is_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .field_number(field_number), .content_offset(content_offset),
    .content_length(content_length), .status(status)
  );

  // 12 ns clock period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Local copy of the parser state, updated as each transaction is accepted.
  logic [7:0]  tag_bytes [SLOT_COUNT][NAME_LEN];
  logic [5:0]  tag_len [SLOT_COUNT];
  logic [4:0]  fields_reg = 5'd1;
  phase_t      phase = P_OPEN;
  logic [4:0]  cur_field = '0;
  int          doc_pos = 0;
  int          tag_idx = 0;
  int          body_start = 0;
  logic [7:0]  close_win [WINDOW];

  // Results still owed by the block, oldest first.
  field_result_t pending_fields[$];

  int  fail_count = 0;
  int  items_sent = 0;
  int  cycle_count = 0;
  // When idling is off the sender leaves no gaps and the receiver adds no random stalls.
  bit  idle_on = 1'b1;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  stall_left = 0;

  function automatic int fields_wanted();
    if (fields_reg == 0) return 1;
    if (fields_reg > 16) return 16;
    return fields_reg;
  endfunction

  function automatic int slot_len(int s);
    return (tag_len[s] > NAME_LEN) ? NAME_LEN : tag_len[s];
  endfunction

  function automatic bit is_ws(logic [7:0] c);
    return c == tdfe_pkg::CH_SP || c == tdfe_pkg::CH_TAB || c == tdfe_pkg::CH_NL;
  endfunction

  function automatic void rearm_parser();
    phase = P_OPEN;
    cur_field = '0;
    doc_pos = 0;
    tag_idx = 0;
    body_start = 0;
    foreach (close_win[i]) close_win[i] = '0;
  endfunction

  // True when the newest bytes of the window spell the close tag of the current field.
  function automatic bit close_tag_seen(int len);
    int m;
    m = len + 3;
    if (close_win[0] != tdfe_pkg::CH_GT || close_win[m-1] != tdfe_pkg::CH_LT ||
        close_win[m-2] != tdfe_pkg::CH_SLASH)
      return 1'b0;
    for (int i = 0; i < len; i++)
      if (close_win[m-3-i] != tag_bytes[cur_field][i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic field_result_t make_result(logic [4:0] f, int off, int len,
                                                logic [2:0] code);
    field_result_t r;
    r.fnum = f;
    r.offset = off[15:0];
    r.length = len[15:0];
    r.code = code;
    return r;
  endfunction

  // Works out the result, if any, that one accepted transaction causes.
  function automatic void track_item(logic m, logic [4:0] s, logic [4:0] p,
                                     logic [7:0] c, logic l);
    field_result_t r;
    bit have;
    int len;
    int seen;
    logic [7:0] want;
    have = 1'b0;
    if (m == tdfe_pkg::MODE_NAME) begin
      if (s < SLOT_COUNT) begin
        tag_bytes[s][p] = c;
        if (l) tag_len[s] = p + 1;
      end
      return;
    end
    if (phase != P_IDLE && doc_pos >= DOC_LIMIT) begin
      r = make_result(cur_field, 0, 0, tdfe_pkg::ST_TOO_LONG);
      have = 1'b1;
      phase = P_IDLE;
    end
    if (phase == P_SPACE && !is_ws(c)) begin
      phase = P_OPEN;
      tag_idx = 0;
    end
    case (phase)
      P_OPEN: begin
        len = slot_len(cur_field);
        want = (tag_idx == 0) ? tdfe_pkg::CH_LT : tag_bytes[cur_field][tag_idx-1];
        if (c != want) begin
          r = make_result(cur_field, 0, 0, tdfe_pkg::ST_MISMATCH);
          have = 1'b1;
          phase = P_IDLE;
        end else begin
          tag_idx++;
          if (tag_idx >= len + 1) phase = P_TO_GT;
        end
      end
      P_TO_GT: begin
        if (c == tdfe_pkg::CH_GT) begin
          if (cur_field == 0) begin
            cur_field = 5'd1;
            phase = P_SPACE;
          end else begin
            body_start = doc_pos + 1;
            foreach (close_win[i]) close_win[i] = '0;
            phase = P_BODY;
          end
        end
      end
      P_BODY: begin
        len = slot_len(cur_field);
        seen = doc_pos + 1 - body_start;
        for (int i = WINDOW - 1; i > 0; i--) close_win[i] = close_win[i-1];
        close_win[0] = c;
        if (seen >= len + 3 && close_tag_seen(len)) begin
          have = 1'b1;
          if (cur_field >= fields_wanted()) begin
            r = make_result(cur_field, body_start, seen - len - 3, tdfe_pkg::ST_LAST);
            phase = P_IDLE;
          end else begin
            r = make_result(cur_field, body_start, seen - len - 3, tdfe_pkg::ST_FOUND);
            cur_field++;
            phase = P_SPACE;
          end
        end
      end
      default: ;
    endcase
    if (doc_pos < DOC_LIMIT) doc_pos++;
    // A last byte that leaves the document unfinished replaces any result of this byte.
    if (l) begin
      if (phase != P_IDLE) begin
        r = make_result(cur_field, 0, 0, tdfe_pkg::ST_EARLY);
        have = 1'b1;
      end
      rearm_parser();
    end
    if (have) pending_fields.push_back(r);
  endfunction

  // Offers one transaction after a random gap and waits until the block takes it.
  // Valid stays high afterwards so that back-to-back transactions need no second write.
  task automatic push_item(logic m, logic [4:0] s, logic [4:0] p, logic [7:0] c, logic l);
    int gap;
    gap = idle_on ? $urandom_range(0, 18) : 0;
    if ($urandom_range(0, 2) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    mode      <= m;
    name_slot <= s;
    name_pos  <= p;
    data_byte <= c;
    is_last   <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_item(m, s, p, c, l);
    items_sent++;
  endtask

  // Drops valid and waits until every owed result has been taken.
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_field_count(logic [4:0] v);
    wait_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    fields_reg = v;
  endtask

  function automatic logic [7:0] name_char();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  // Loads a full tag name; the final byte carries the length.
  task automatic load_name(logic [4:0] s, int len);
    for (int i = 0; i < len; i++)
      push_item(tdfe_pkg::MODE_NAME, s, 5'(i), name_char(), i == len - 1);
  endtask

  function automatic void add_ws(ref logic [7:0] q[$]);
    int n;
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++)
      case ($urandom_range(0, 2))
        0: q.push_back(tdfe_pkg::CH_SP);
        1: q.push_back(tdfe_pkg::CH_TAB);
        default: q.push_back(tdfe_pkg::CH_NL);
      endcase
  endfunction

  // Bytes up to the closing bracket of an open tag, never the bracket itself.
  function automatic void add_attrs(ref logic [7:0] q[$]);
    int n;
    logic [7:0] b;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      q.push_back(b == tdfe_pkg::CH_GT ? tdfe_pkg::CH_SP : b);
    end
  endfunction

  // Builds a well-formed document for the given number of fields using the loaded names.
  function automatic void build_doc(int nf, int max_content, ref logic [7:0] q[$]);
    int n;
    q.delete();
    q.push_back(tdfe_pkg::CH_LT);
    for (int i = 0; i < slot_len(0); i++) q.push_back(tag_bytes[0][i]);
    add_attrs(q);
    q.push_back(tdfe_pkg::CH_GT);
    add_ws(q);
    for (int f = 1; f <= nf; f++) begin
      q.push_back(tdfe_pkg::CH_LT);
      for (int i = 0; i < slot_len(f); i++) q.push_back(tag_bytes[f][i]);
      add_attrs(q);
      q.push_back(tdfe_pkg::CH_GT);
      n = $urandom_range(0, max_content);
      for (int i = 0; i < n; i++)
        q.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                : 8'($urandom_range(8'h41, 8'h5A)));
      q.push_back(tdfe_pkg::CH_LT);
      q.push_back(tdfe_pkg::CH_SLASH);
      for (int i = 0; i < slot_len(f); i++) q.push_back(tag_bytes[f][i]);
      q.push_back(tdfe_pkg::CH_GT);
      add_ws(q);
    end
  endfunction

  // Streams a document; the final byte is marked last. Name reloads may be mixed in.
  task automatic send_doc(logic [7:0] q[$], int reload_pct);
    for (int i = 0; i < q.size(); i++) begin
      if ($urandom_range(0, 99) < reload_pct)
        load_name(5'($urandom_range(0, 16)), $urandom_range(1, 4));
      push_item(tdfe_pkg::MODE_DOC, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                q[i], i == q.size() - 1);
    end
  endtask

  // Loads every slot so that no unwritten name is ever compared, plus ignored slots.
  task automatic test_name_loading();
    load_name(5'd0, NAME_LEN);
    for (int s = 1; s < SLOT_COUNT; s++) load_name(5'(s), $urandom_range(1, 4));
    push_item(tdfe_pkg::MODE_NAME, 5'd17, 5'd0, 8'hFF, 1'b1);
    push_item(tdfe_pkg::MODE_NAME, 5'd31, 5'd31, 8'h00, 1'b1);
    load_name(5'd0, 3);
  endtask

  task automatic test_field_counts();
    logic [7:0] q[$];
    logic [4:0] counts[4] = '{5'd1, 5'd0, 5'd16, 5'd31};
    foreach (counts[k]) begin
      write_field_count(counts[k]);
      build_doc(fields_wanted(), 4, q);
      // Trailing bytes after success are ignored until the last one.
      q.push_back(8'h00);
      q.push_back(tdfe_pkg::CH_LT);
      send_doc(q, 0);
    end
  endtask

  task automatic test_faults();
    logic [7:0] q[$];
    write_field_count(5'd3);
    // Wrong byte in the document open tag.
    build_doc(3, 3, q);
    q[1] = ~q[1];
    send_doc(q, 0);
    // Byte flipped just after the document tag name: an attribute, white space or the first field tag.
    build_doc(3, 3, q);
    q[slot_len(0) + 3] = ~q[slot_len(0) + 3];
    send_doc(q, 0);
    // Document cut off halfway, and a document that is only an open bracket.
    build_doc(3, 3, q);
    q = q[0:q.size() / 2];
    send_doc(q, 0);
    q = '{tdfe_pkg::CH_LT};
    send_doc(q, 0);
    // Document ends after a field that is not the final one.
    build_doc(1, 3, q);
    send_doc(q, 0);
    // Names of random slots reloaded while the document streams.
    build_doc(3, 3, q);
    send_doc(q, 8);
  endtask

  // The receiver holds off while the sender keeps going, then the sender waits for all.
  task automatic test_backpressure();
    logic [7:0] q[$];
    write_field_count(5'd16);
    idle_on = 1'b0;
    hold_req = 1'b1;
    for (int k = 0; k < 3; k++) begin
      build_doc(16, 1, q);
      send_doc(q, 0);
    end
    idle_on = 1'b1;
    wait_drain();
  endtask

  task automatic test_random_docs();
    logic [7:0] q[$];
    int r;
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 6) == 0) begin
        r = $urandom_range(0, 5);
        write_field_count(r == 0 ? 5'd0 : r == 1 ? 5'd31 : r == 2 ? 5'd16
                                               : 5'($urandom_range(1, 4)));
      end
      if ($urandom_range(0, 9) == 0) idle_on = ~idle_on;
      if ($urandom_range(0, 11) == 0) load_name(5'($urandom_range(0, 16)),
                                                 $urandom_range(1, 6));
      build_doc(fields_wanted() > 4 ? $urandom_range(1, fields_wanted()) : fields_wanted(),
                6, q);
      case ($urandom_range(0, 7))
        0: q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
        1: q = q[0:$urandom_range(0, q.size() - 1)];
        2: for (int i = 0; i < 3; i++) q.push_back(8'($urandom_range(0, 255)));
        default: ;
      endcase
      send_doc(q, 2);
    end
    idle_on = 1'b1;
  endtask

  // Receiver: random stall per result, occasionally a long hold-off.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 400;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (out_valid && !out_stall && idle_on) stall_left = $urandom_range(0, 18);
    end
  end

  // Checks each accepted result against the oldest one owed.
  always @(posedge clk) begin
    field_result_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_fields.size() == 0) begin
        $error("unexpected result: field %0d status %0d", field_number, status);
        fail_count++;
      end else begin
        e = pending_fields.pop_front();
        if (field_number !== e.fnum) begin
          $error("field_number: expected %0d, got %0d", e.fnum, field_number);
          fail_count++;
        end
        if (content_offset !== e.offset) begin
          $error("content_offset: expected %0d, got %0d", e.offset, content_offset);
          fail_count++;
        end
        if (content_length !== e.length) begin
          $error("content_length: expected %0d, got %0d", e.length, content_length);
          fail_count++;
        end
        if (status !== e.code) begin
          $error("status: expected %0d, got %0d", e.code, status);
          fail_count++;
        end
      end
    end
  end

  // Guards against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    foreach (tag_len[i]) tag_len[i] = '0;
    foreach (tag_bytes[i, j]) tag_bytes[i][j] = '0;
    rearm_parser();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_name_loading();
    test_field_counts();
    test_faults();
    test_backpressure();
    test_random_docs();
    wait_drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
